// File: rtl/dhp_pkg.sv
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared types, sizes and tables for the 3x3 depth hole pre-fill block.
// ----------------------------------------------------------------------------
package dhp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int DEPTH_BITS = 16;

  localparam int COL_W    = $clog2(MAX_WIDTH);     // column index
  localparam int WIDTH_W  = COL_W + 1;             // holds MAX_WIDTH itself
  localparam int HEIGHT_W = 13;                    // frame_height register
  localparam int ROW_W    = HEIGHT_W;              // row index
  localparam int PEND_W   = WIDTH_W;               // pending results, up to width + 1
  localparam int CELL_W   = DEPTH_BITS + 1;
  localparam int CNT_W    = 4;                     // up to eight neighbours
  localparam int SUM_W    = DEPTH_BITS + 3;        // sum of eight samples
  localparam int RECIP_SHIFT = SUM_W + 1;
  localparam int RECIP_W  = RECIP_SHIFT + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
  localparam logic [11:0]         WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [15:0]         THR_RESET    = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_RANGE_THRESHOLD = 2'd2
  } reg_index_t;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_t;

  typedef struct packed {
    logic                  func;
    logic [DEPTH_BITS-1:0] pixel_value;
    logic                  pixel_valid;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] out_value;
    logic                  out_valid;
    logic                  out_last;
  } res_item_t;

  typedef struct packed {
    logic                  valid;
    logic [DEPTH_BITS-1:0] value;
  } cell_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_MUL,
    S_FIX
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // capture the input beat
    logic shift;      // shift the window, write the line store, advance position
    logic hole;       // shift an invalid dummy cell instead of the captured pixel
    logic pend_inc;
    logic pend_dec;
    logic drain_set;
    logic drain_end;  // last pending result: leave draining, rewind position
    logic sum_en;
    logic mul_en;
    logic fix_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_flush;
    logic draining;
    logic pend_zero;
    logic pend_one;
    logic pend_gt_w;
    logic at_origin;
    logic out_busy;
  } status_t;

  // floor(2^RECIP_SHIFT / n) for n = 1..8.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd1:    r = RECIP_W'(1048576);
      4'd2:    r = RECIP_W'(524288);
      4'd3:    r = RECIP_W'(349525);
      4'd4:    r = RECIP_W'(262144);
      4'd5:    r = RECIP_W'(209715);
      4'd6:    r = RECIP_W'(174762);
      4'd7:    r = RECIP_W'(149796);
      4'd8:    r = RECIP_W'(131072);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/dhp_ram.sv
// ----------------------------------------------------------------------------
// dhp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dhp_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/dhp_ctrl.sv
// ----------------------------------------------------------------------------
// dhp_ctrl
// Sequencer: takes one beat, decides its action and steps the datapath.
// ----------------------------------------------------------------------------
module dhp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dhp_pkg::status_t status,
  output dhp_pkg::cmd_t    cmd
);
  import dhp_pkg::*;

  state_t state;
  state_t state_next;
  logic   act_ignore;
  logic   act_emit;
  logic   act_enter;
  logic   act_end;

  // Action for the captured beat, valid in S_SHIFT.
  always_comb begin
    act_ignore = 1'b0;
    act_emit   = 1'b0;
    act_enter  = 1'b0;
    act_end    = 1'b0;
    if (!status.is_flush) begin
      if (status.draining) begin
        act_ignore = 1'b1;
      end else begin
        act_emit = status.pend_gt_w;
      end
    end else begin
      if (!status.draining && (status.pend_zero || !status.at_origin)) begin
        act_ignore = 1'b1;
      end else begin
        act_emit  = 1'b1;
        act_enter = !status.draining;
        act_end   = status.pend_one;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        state_next = (!act_ignore && act_emit) ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_FIX;
      end
      S_FIX: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = rst || (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid && !rst;
      end
      S_SHIFT: begin
        if (!act_ignore) begin
          cmd.shift     = 1'b1;
          cmd.hole      = status.is_flush;
          cmd.pend_inc  = !status.is_flush && !act_emit;
          cmd.pend_dec  = status.is_flush;
          cmd.drain_set = act_enter;
          cmd.drain_end = act_end;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
      end
      S_FIX: begin
        cmd.fix_en = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/dhp_datapath.sv
// ----------------------------------------------------------------------------
// dhp_datapath
// Configuration, positions, line store, 3x3 window, fill arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module dhp_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [dhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhp_pkg::CFG_W-1:0]  cfg_data,
  input  dhp_pkg::in_item_t          in_item,
  output logic                       res_valid,
  input  logic                       res_stall,
  output dhp_pkg::res_item_t         res_item,
  input  dhp_pkg::cmd_t              cmd,
  output dhp_pkg::status_t           status
);
  import dhp_pkg::*;

  // Configuration.
  logic [11:0]           frame_width;
  logic [HEIGHT_W-1:0]   frame_height;
  logic [15:0]           range_threshold;
  logic [WIDTH_W-1:0]    eff_w;
  logic [HEIGHT_W-1:0]   eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= WIDTH_RESET;
      frame_height    <= HEIGHT_RESET;
      range_threshold <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     frame_width     <= cfg_data[11:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data[HEIGHT_W-1:0];
        REG_RANGE_THRESHOLD: range_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (WIDTH_W'(frame_width) < WIDTH_MIN) begin
      eff_w = WIDTH_MIN;
    end else if (WIDTH_W'(frame_width) > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = WIDTH_W'(frame_width);
    end
    eff_h = (frame_height < HEIGHT_MIN) ? HEIGHT_MIN : frame_height;
  end

  // Captured input beat.
  in_item_t item;

  always_ff @(posedge clk) begin
    if (cmd.take) item <= in_item;
  end

  // Input position, pending count and draining flag.
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PEND_W-1:0] pending;
  logic              draining;
  logic [WIDTH_W-1:0] col_inc;
  logic [ROW_W:0]     row_inc;

  assign col_inc = WIDTH_W'(col) + WIDTH_W'(1);
  assign row_inc = (ROW_W+1)'(row) + (ROW_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      pending  <= '0;
      draining <= 1'b0;
    end else if (cmd.shift) begin
      if (cmd.drain_end) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= eff_w) begin
        col <= '0;
        row <= (row_inc >= (ROW_W+1)'(eff_h)) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col <= col_inc[COL_W-1:0];
      end
      if (cmd.pend_inc) begin
        pending <= pending + PEND_W'(1);
      end else if (cmd.pend_dec) begin
        pending <= pending - PEND_W'(1);
      end
      if (cmd.drain_end) begin
        draining <= 1'b0;
      end else if (cmd.drain_set) begin
        draining <= 1'b1;
      end
    end
  end

  // Line store: each word holds the upper and the middle row cell of a column.
  logic [2*CELL_W-1:0] line_rd;
  logic [2*CELL_W-1:0] line_wr;
  cell_t               upper_cell;
  cell_t               middle_cell;
  cell_t               new_cell;

  assign upper_cell  = line_rd[2*CELL_W-1:CELL_W];
  assign middle_cell = line_rd[CELL_W-1:0];

  always_comb begin
    new_cell = '0;
    if (!cmd.hole && item.pixel_valid) begin
      new_cell.valid = 1'b1;
      new_cell.value = item.pixel_value;
    end
  end

  assign line_wr = {middle_cell, new_cell};

  dhp_ram #(
    .WIDTH (2*CELL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (cmd.shift),
    .wr_addr (col),
    .wr_data (line_wr),
    .rd_addr (col),
    .rd_data (line_rd)
  );

  // 3x3 window, index = row * 3 + column, column 2 being the newest.
  cell_t win [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= upper_cell;
      win[5] <= middle_cell;
      win[8] <= new_cell;
    end
  end

  // Output position.
  logic [COL_W-1:0]   out_col;
  logic [ROW_W-1:0]   out_row;
  logic [WIDTH_W-1:0] out_col_inc;
  logic [ROW_W:0]     out_row_inc;
  logic               interior;
  logic               last;

  assign out_col_inc = WIDTH_W'(out_col) + WIDTH_W'(1);
  assign out_row_inc = (ROW_W+1)'(out_row) + (ROW_W+1)'(1);
  assign interior = (out_row != '0) && (out_row_inc < (ROW_W+1)'(eff_h)) &&
                    (out_col != '0) && (out_col_inc < eff_w);
  assign last = (out_row_inc >= (ROW_W+1)'(eff_h)) && (out_col_inc >= eff_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_col <= '0;
      out_row <= '0;
    end else if (cmd.sum_en) begin
      if (out_col_inc >= eff_w) begin
        out_col <= '0;
        out_row <= (out_row_inc >= (ROW_W+1)'(eff_h)) ? '0 : out_row_inc[ROW_W-1:0];
      end else begin
        out_col <= out_col_inc[COL_W-1:0];
      end
    end
  end

  // First arithmetic stage: sum, count, minimum and maximum of valid neighbours.
  logic [SUM_W-1:0]      sum_c;
  logic [CNT_W-1:0]      cnt_c;
  logic [DEPTH_BITS-1:0] mn_c;
  logic [DEPTH_BITS-1:0] mx_c;
  logic [8:0]            nv;
  logic                  groups_c;

  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    mn_c  = '1;
    mx_c  = '0;
    for (int i = 0; i < 9; i++) begin
      nv[i] = (i != 4) && win[i].valid;
      if (nv[i]) begin
        sum_c = sum_c + SUM_W'(win[i].value);
        cnt_c = cnt_c + CNT_W'(1);
        if (win[i].value < mn_c) mn_c = win[i].value;
        if (win[i].value > mx_c) mx_c = win[i].value;
      end
    end
    groups_c = (nv[0] || nv[1] || nv[3]) && (nv[6] || nv[3] || nv[7]) &&
               (nv[2] || nv[5] || nv[1]) && (nv[8] || nv[5] || nv[7]);
  end

  logic [SUM_W-1:0]      s1_sum;
  logic [CNT_W-1:0]      s1_cnt;
  logic [DEPTH_BITS-1:0] s1_mn;
  logic [DEPTH_BITS-1:0] s1_mx;
  logic                  s1_groups;
  cell_t                 s1_centre;
  logic                  s1_interior;
  logic                  s1_last;

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      s1_sum      <= sum_c;
      s1_cnt      <= cnt_c;
      s1_mn       <= mn_c;
      s1_mx       <= mx_c;
      s1_groups   <= groups_c;
      s1_centre   <= win[4];
      s1_interior <= interior;
      s1_last     <= last;
    end
  end

  // Second stage: multiply by the reciprocal of the count, check the range.
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  s2_q;
  logic [SUM_W-1:0]  s2_sum;
  logic [CNT_W-1:0]  s2_cnt;
  logic              s2_fill;
  cell_t             s2_centre;
  logic              s2_last;

  assign prod = PROD_W'(s1_sum) * PROD_W'(recip(s1_cnt));

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      s2_q      <= prod[RECIP_SHIFT +: SUM_W];
      s2_sum    <= s1_sum;
      s2_cnt    <= s1_cnt;
      s2_fill   <= s1_interior && s1_groups && (s1_cnt != '0) &&
                   ((s1_mx - s1_mn) < range_threshold);
      s2_centre <= s1_centre;
      s2_last   <= s1_last;
    end
  end

  // Third stage: the estimate is at most one below the quotient; correct it.
  logic [SUM_W+CNT_W-1:0] qn;
  logic [SUM_W+CNT_W-1:0] rem;
  logic [SUM_W-1:0]       q_fix;
  res_item_t              res_next;

  assign qn    = (SUM_W+CNT_W)'(s2_q) * (SUM_W+CNT_W)'(s2_cnt);
  assign rem   = (SUM_W+CNT_W)'(s2_sum) - qn;
  assign q_fix = (rem >= (SUM_W+CNT_W)'(s2_cnt)) ? s2_q + SUM_W'(1) : s2_q;

  always_comb begin
    res_next          = '0;
    res_next.out_last = s2_last;
    if (s2_centre.valid) begin
      res_next.out_value = s2_centre.value;
      res_next.out_valid = 1'b1;
    end else if (s2_fill) begin
      res_next.out_value = q_fix[DEPTH_BITS-1:0];
      res_next.out_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.fix_en) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix_en) res_item <= res_next;
  end

  always_comb begin
    status.is_flush  = (item.func == FUNC_FLUSH);
    status.draining  = draining;
    status.pend_zero = (pending == '0);
    status.pend_one  = (pending == PEND_W'(1));
    status.pend_gt_w = (pending > eff_w);
    status.at_origin = (col == '0) && (row == '0);
    status.out_busy  = res_valid && res_stall;
  end

endmodule

// File: rtl/depth_hole_prefill_3x3_top.sv
// ----------------------------------------------------------------------------
// depth_hole_prefill_3x3_top
// Streaming 3x3 hole pre-fill for raster depth images.
// ----------------------------------------------------------------------------
// Latency: a result leaves frame_width + 1 input beats after its pixel, the width
// clamped to 3..2048; the last fill stage writes it to the output register.
// Sequence: each beat is captured and decided on, and shifts the window unless
// it is dropped; one that releases a result then passes the three fill stages.
// Reset: synchronous, active high; 640 x 480 with a 50 mm range limit, window
// cleared, line store left as it is.
// ----------------------------------------------------------------------------
module depth_hole_prefill_3x3_top (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_write,
  input  logic [dhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhp_pkg::CFG_W-1:0]     cfg_data,
  // Input beats: pixels and flush requests.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dhp_pkg::in_item_t             in_item,
  // Result beats.
  output logic                          res_valid,
  input  logic                          res_stall,
  output dhp_pkg::res_item_t            res_item
);
  import dhp_pkg::*;

  // The controller owns the sequence of an item; the datapath owns every
  // register that carries data or position. They talk only through these.
  cmd_t    cmd;
  status_t status;

  // The controller accepts a beat only from its idle state. In the following
  // cycle the line store read data are present and it decides what the beat
  // does: a pixel while draining, or a flush that arrives mid-frame or with
  // nothing pending, is dropped without touching any state. Otherwise the
  // window shifts, and if a result is due the three fill stages follow.
  dhp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the line store (one word per column carrying the cells
  // of the two previous rows), the 3x3 window, the input and output positions
  // and the fill arithmetic. The fill value is the floor of the neighbour mean,
  // formed as a multiplication by a reciprocal followed by a one-step
  // correction. The result sits in an output register, so the next beat may
  // be accepted while a finished result still waits to be taken.
  dhp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: rtl/dhp_checker.sv
// ----------------------------------------------------------------------------
// dhp_checker
// Port-level assertions for the depth hole pre-fill block.
// ----------------------------------------------------------------------------
module dhp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          res_valid,
  input logic                          res_stall,
  input dhp_pkg::res_item_t            res_item
);
  import dhp_pkg::*;

  // A stalled result beat holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result beat changed while stalled");

  // Items are worked on one at a time: an accepted beat blocks the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("beat accepted while previous item still in work");

  // A result can only appear at the end of an item's work.
  a_res_from_work: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(res_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // A hole leaves with a zero value.
  a_hole_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.out_valid |-> res_item.out_value == '0)
    else $error("invalid result carries a non-zero value");

endmodule

bind depth_hole_prefill_3x3_top dhp_checker u_dhp_checker (.*);
